>>> rtl/core/cbpe_pkg.sv
// Shared constants and types of the cubic Bezier point evaluator.
package cbpe_pkg;

  // Steps per curve, as a power of two (at least 3 so that the rounding shift stays positive).
  localparam int STEPS_LG2 = 8;
  localparam int STEPS     = 1 << STEPS_LG2;

  localparam int IDX_W     = 9;   // step index port
  localparam int CTRL_W    = 11;  // control point coordinate
  localparam int OUT_W     = 19;  // curve coordinate
  localparam int FRAC_BITS = 8;

  localparam int T_W    = STEPS_LG2 + 1;       // i and STEPS - i
  localparam int SQ_W   = 2 * STEPS_LG2 + 1;   // squares and 3*u*i
  localparam int WGT_W  = 3 * STEPS_LG2 + 1;   // Bernstein weights
  localparam int PROD_W = WGT_W + CTRL_W;      // weight times coordinate, signed
  localparam int SUM_W  = PROD_W;              // the weighted sum stays inside the hull
  localparam int SHIFT  = 3 * STEPS_LG2 - FRAC_BITS;
  localparam int RND_W  = SUM_W - SHIFT;

  localparam int NUM_REGS = 8;
  localparam int REG_IDX_W = $clog2(NUM_REGS);

  typedef enum logic [REG_IDX_W-1:0] {
    CFG_X0 = 3'd0,
    CFG_Y0 = 3'd1,
    CFG_X1 = 3'd2,
    CFG_Y1 = 3'd3,
    CFG_X2 = 3'd4,
    CFG_Y2 = 3'd5,
    CFG_X3 = 3'd6,
    CFG_Y3 = 3'd7
  } cfg_reg_e;

  typedef logic signed [CTRL_W-1:0] ctrl_t;
  typedef logic [T_W-1:0]           tval_t;
  typedef logic [SQ_W-1:0]          sq_t;
  typedef logic [WGT_W-1:0]         wgt_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [OUT_W-1:0]  coord_t;

  localparam ctrl_t CTRL_RESET [NUM_REGS] = '{
    11'sd100, 11'sd450, 11'sd200, 11'sd480, 11'sd200, 11'sd420, 11'sd270, 11'sd450
  };

endpackage

>>> rtl/core/cubic_bezier_point_eval.sv
// Cubic Bezier point evaluator: six-stage pipeline from step index to curve point.
//
// Usage: the four control points are written through the configuration port
// (cfg_we_i, cfg_idx_i, cfg_wdata_i), one coordinate per write, and take effect
// at once; they should only change while no beat is in flight. A step index is
// taken at each rising edge with start_i high and busy_o low. busy_o is always
// low, so a new index can be given in every cycle. The index saturates at STEPS,
// which yields the last control point.
// Each accepted beat produces exactly one point on curve_x_o / curve_y_o, shown
// for one cycle with done_o high after the last register stage. Points come out in
// the order the indices went in, one per clock at full rate.
// Throughput: one point per cycle; the latency is set by the six register
// stages (index, products u*u / i*i / 3*u*i, weights, coordinate products,
// weighted sums, rounding and saturation).
// The receiver cannot stall, so no back-pressure exists inside the pipe.
// Reset clears the pipeline valid bits, so no point emerges from a beat taken
// before reset, and restores the default control points.
module cubic_bezier_point_eval (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cbpe_pkg::REG_IDX_W-1:0]    cfg_idx_i,
  input  logic signed [cbpe_pkg::CTRL_W-1:0] cfg_wdata_i,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [cbpe_pkg::IDX_W-1:0]        step_index_i,
  output logic                              done_o,
  output logic signed [cbpe_pkg::OUT_W-1:0] curve_x_o,
  output logic signed [cbpe_pkg::OUT_W-1:0] curve_y_o
);
  import cbpe_pkg::*;

  localparam int LAT = 6;
  localparam sum_t RND = sum_t'(1) << (SHIFT - 1);
  localparam logic signed [RND_W-1:0] R_MAX =
    {{(RND_W - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
  localparam logic signed [RND_W-1:0] R_MIN = ~R_MAX;

  ctrl_t ctrl_q [NUM_REGS];

  logic [LAT-1:0] vld_q, vld_d;

  tval_t i1_q, u1_q, i1_d, u1_d;
  tval_t i2_q, u2_q;
  sq_t   uu2_q, ii2_q, ui3_q, uu2_d, ii2_d, ui3_d;
  wgt_t  w3_q [4];
  wgt_t  w3_d [4];
  prod_t px4_q [4];
  prod_t py4_q [4];
  prod_t px4_d [4];
  prod_t py4_d [4];
  sum_t  sx5_q, sy5_q, sx5_d, sy5_d;
  coord_t x6_q, y6_q, x6_d, y6_d;

  logic accept;

  function automatic coord_t round_sat(sum_t s);
    sum_t                    biased;
    logic signed [RND_W-1:0] r;
    biased = s + RND;
    r      = biased[SUM_W-1:SHIFT];
    if (r > R_MAX) begin
      r = R_MAX;
    end else if (r < R_MIN) begin
      r = R_MIN;
    end
    return r[OUT_W-1:0];
  endfunction

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_REGS; k++) begin
        ctrl_q[k] <= CTRL_RESET[k];
      end
    end else if (cfg_we_i) begin
      ctrl_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  assign vld_d = {vld_q[LAT-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_comb begin
    // Stage 1: saturate the index and form u = STEPS - i.
    if (step_index_i > IDX_W'(STEPS)) begin
      i1_d = tval_t'(STEPS);
    end else begin
      i1_d = tval_t'(step_index_i);
    end
    u1_d = tval_t'(STEPS) - i1_d;

    // Stage 2: second-order products.
    uu2_d = sq_t'(u1_q * u1_q);
    ii2_d = sq_t'(i1_q * i1_q);
    ui3_d = sq_t'(u1_q * i1_q);
    ui3_d = ui3_d + (ui3_d << 1);

    // Stage 3: Bernstein weights scaled by STEPS cubed.
    w3_d[0] = wgt_t'(uu2_q * u2_q);
    w3_d[1] = wgt_t'(ui3_q * u2_q);
    w3_d[2] = wgt_t'(ui3_q * i2_q);
    w3_d[3] = wgt_t'(ii2_q * i2_q);

    // Stage 4: weight times control point coordinate.
    px4_d[0] = $signed({1'b0, w3_q[0]}) * ctrl_q[CFG_X0];
    px4_d[1] = $signed({1'b0, w3_q[1]}) * ctrl_q[CFG_X1];
    px4_d[2] = $signed({1'b0, w3_q[2]}) * ctrl_q[CFG_X2];
    px4_d[3] = $signed({1'b0, w3_q[3]}) * ctrl_q[CFG_X3];
    py4_d[0] = $signed({1'b0, w3_q[0]}) * ctrl_q[CFG_Y0];
    py4_d[1] = $signed({1'b0, w3_q[1]}) * ctrl_q[CFG_Y1];
    py4_d[2] = $signed({1'b0, w3_q[2]}) * ctrl_q[CFG_Y2];
    py4_d[3] = $signed({1'b0, w3_q[3]}) * ctrl_q[CFG_Y3];

    // Stage 5: weighted sums.
    sx5_d = px4_q[0] + px4_q[1] + px4_q[2] + px4_q[3];
    sy5_d = py4_q[0] + py4_q[1] + py4_q[2] + py4_q[3];

    // Stage 6: round half up to 8 fraction bits and clamp.
    x6_d = round_sat(sx5_q);
    y6_d = round_sat(sy5_q);
  end

  // Datapath registers need no reset; the valid bits qualify them.
  always_ff @(posedge clk_i) begin
    i1_q  <= i1_d;
    u1_q  <= u1_d;
    i2_q  <= i1_q;
    u2_q  <= u1_q;
    uu2_q <= uu2_d;
    ii2_q <= ii2_d;
    ui3_q <= ui3_d;
    for (int k = 0; k < 4; k++) begin
      w3_q[k]  <= w3_d[k];
      px4_q[k] <= px4_d[k];
      py4_q[k] <= py4_d[k];
    end
    sx5_q <= sx5_d;
    sy5_q <= sy5_d;
    x6_q  <= x6_d;
    y6_q  <= y6_d;
  end

  assign done_o    = vld_q[LAT-1];
  assign curve_x_o = x6_q;
  assign curve_y_o = y6_q;

  // A point only leaves for a beat that was accepted earlier and ran the whole pipe.
  a_done_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LAT))
    else $error("done_o without a matching accepted beat");

  // The index and its complement always add up to STEPS.
  a_index_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> (32'(i1_q) + 32'(u1_q) == 32'(STEPS)))
    else $error("step index pair does not sum to STEPS");

  // The Bernstein weights form a partition of unity.
  a_weight_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] |-> (64'(w3_q[0]) + 64'(w3_q[1]) + 64'(w3_q[2]) + 64'(w3_q[3])
                  == (64'd1 << (3 * STEPS_LG2))))
    else $error("Bernstein weights do not sum to STEPS cubed");

endmodule
